// ===== sv/ocrpc_pkg.sv =====
// ocrpc_pkg: shared types, register indexes, reset values and byte class
// helpers for the text line plausibility checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ocrpc_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_LINE_REPEAT  = 3'd0;
    localparam logic [2:0] REG_GEO_REPEAT   = 3'd1;
    localparam logic [2:0] REG_GEO_NUMERIC  = 3'd2;
    localparam logic [2:0] REG_GEO_PURE     = 3'd3;
    localparam logic [2:0] REG_SMALL_MAX    = 3'd4;
    localparam logic [2:0] REG_SMALL_NUMBER = 3'd5;

    localparam logic [6:0] RST_LINE_REPEAT  = 7'd75;
    localparam logic [6:0] RST_GEO_REPEAT   = 7'd55;
    localparam logic [6:0] RST_GEO_NUMERIC  = 7'd70;
    localparam logic [6:0] RST_GEO_PURE     = 7'd85;
    localparam logic [7:0] RST_SMALL_MAX    = 8'd32;
    localparam logic [6:0] RST_SMALL_NUMBER = 7'd60;

    localparam logic [7:0] MIN_ALPHA_LONG   = 8'd3;
    localparam logic signed [12:0] SCORE_LIMIT = 13'sd1600;

    localparam int OUT_DATA_W = 32;

    typedef struct packed {
        logic [6:0] line_repeat_percent;
        logic [6:0] geometry_repeat_percent;
        logic [6:0] geometry_numeric_percent;
        logic [6:0] geometry_pure_percent;
        logic [7:0] small_max_glyphs;
        logic [6:0] small_numeric_percent;
    } cfg_t;

    // per line counts, edge bit0 first glyph punct, bit1 last glyph punct,
    // bit2 a glyph was seen
    typedef struct packed {
        logic [7:0] glyphs;
        logic [7:0] letters;
        logic [7:0] digits;
        logic [7:0] puncts;
        logic [7:0] others;
        logic [7:0] spaces;
        logic [7:0] top_freq;
        logic [2:0] edge_flags;
        logic       ovf;
    } line_stats_t;

    typedef struct packed {
        logic              line_plausible;
        logic              small_plausible;
        logic              numeric_geometry;
        logic              repetitive_geometry;
        logic              punctuation_geometry;
        logic signed [11:0] composition_score;
        logic [7:0]        glyph_count;
        logic              overflow;
    } verdict_t;

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || c == 8'd9 || c == 8'd13 || c == 8'd10;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c == 8'h2D || c == 8'h2B || c == 8'h3D || c == 8'h7C ||
               c == 8'h5F || c == 8'h2E || c == 8'h2C || c == 8'h3A ||
               c == 8'h3B || c == 8'h2A || c == 8'h60 || c == 8'h27 ||
               c == 8'h22 || c == 8'h7E || c == 8'h2F || c == 8'h5C;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // saturating increment, stops at all ones
    function automatic logic [7:0] sat_inc(input logic [7:0] x);
        return (x == 8'hFF) ? x : x + 8'd1;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ocrpc_ram.sv =====
// ocrpc_ram: generic single write, single read RAM with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ocrpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                       aclk,
    input  wire                       wr_en,
    input  wire [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire [WIDTH-1:0]           wr_data,
    input  wire                       rd_en,
    input  wire [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/ocrpc_verdict.sv =====
// ocrpc_verdict: turns the final counts of one line into the verdicts,
// geometry flags and composition score; uses ocrpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module ocrpc_verdict (
    input  wire ocrpc_pkg::line_stats_t stats,
    input  wire ocrpc_pkg::cfg_t        cfg,
    output ocrpc_pkg::verdict_t         verdict
);
    import ocrpc_pkg::*;

    logic [7:0]  g, a, d, p, o, s, m;
    logic [8:0]  alnum;
    logic [9:0]  normal;
    logic [15:0] top_x100, dig_x100;
    logic [15:0] line_rep_lim, geo_rep_lim, small_num_lim;
    logic [16:0] geo_num_lim, geo_pure_lim;
    logic        line_ok, small_ok, numeric, repetitive, punct_geo;
    logic [10:0] pos_sum;
    logic [11:0] neg_sum;
    logic signed [12:0] score_raw;
    logic signed [12:0] score_clamped;

    always_comb begin
        g = stats.glyphs;
        a = stats.letters;
        d = stats.digits;
        p = stats.puncts;
        o = stats.others;
        s = stats.spaces;
        m = stats.top_freq;

        alnum  = 9'(a) + 9'(d);
        normal = 10'(a) + 10'(d) + 10'(p) + 10'(o);

        top_x100      = 16'(m) * 16'd100;
        dig_x100      = 16'(d) * 16'd100;
        line_rep_lim  = 16'(cfg.line_repeat_percent) * 16'(g);
        geo_rep_lim   = 16'(cfg.geometry_repeat_percent) * 16'(g);
        small_num_lim = 16'(cfg.small_numeric_percent) * 16'(g);
        geo_num_lim   = 17'(cfg.geometry_numeric_percent) * 17'(normal);
        geo_pure_lim  = 17'(cfg.geometry_pure_percent) * 17'(normal);

        // general verdict, first failing test wins
        line_ok = 1'b1;
        if (g == 8'd0 || (a == 8'd0 && d == 8'd0)) begin
            line_ok = 1'b0;
        end else if (g == 8'd1 && d == 8'd1) begin
            line_ok = 1'b0;
        end else if (g >= 8'd6 && top_x100 >= line_rep_lim) begin
            line_ok = 1'b0;
        end else if (9'(o) > alnum) begin
            line_ok = 1'b0;
        end else if (stats.edge_flags[1:0] != 2'b00) begin
            line_ok = 1'b0;
        end

        small_ok = line_ok;
        if (g > cfg.small_max_glyphs) begin
            small_ok = 1'b0;
        end
        if (g >= 8'd6 && dig_x100 >= small_num_lim && a <= 8'd2) begin
            small_ok = 1'b0;
        end
        if (g >= 8'd12 && a < MIN_ALPHA_LONG) begin
            small_ok = 1'b0;
        end

        numeric = 1'b0;
        if (g >= 8'd4 && d != 8'd0 && normal != 10'd0 &&
            17'(dig_x100) >= geo_num_lim) begin
            if (a <= 8'd2 && p <= 8'd2 && o <= 8'd1) begin
                numeric = 1'b1;
            end else if (a == 8'd0 && o == 8'd0 && 17'(dig_x100) >= geo_pure_lim) begin
                numeric = 1'b1;
            end
        end

        repetitive = g >= 8'd4 && top_x100 >= geo_rep_lim;
        punct_geo  = p != 8'd0 && 9'(p) >= alnum;

        pos_sum = 11'(a) * 11'd5 + 11'(d) + 11'(s);
        neg_sum = 12'(p) * 12'd4 + 12'(o) * 12'd5;
        if (repetitive) begin
            neg_sum = neg_sum + 12'd100;
        end
        if (numeric) begin
            neg_sum = neg_sum + 12'd100;
        end
        if (g >= 8'd8 && a < MIN_ALPHA_LONG) begin
            neg_sum = neg_sum + 12'd30;
        end
        score_raw = $signed({2'b00, pos_sum}) - $signed({1'b0, neg_sum});

        if (score_raw > SCORE_LIMIT) begin
            score_clamped = SCORE_LIMIT;
        end else if (score_raw < -SCORE_LIMIT) begin
            score_clamped = -SCORE_LIMIT;
        end else begin
            score_clamped = score_raw;
        end

        verdict.line_plausible       = line_ok;
        verdict.small_plausible      = small_ok;
        verdict.numeric_geometry     = numeric;
        verdict.repetitive_geometry  = repetitive;
        verdict.punctuation_geometry = punct_geo;
        verdict.composition_score    = score_clamped[11:0];
        verdict.glyph_count          = g;
        verdict.overflow             = stats.ovf;
    end

endmodule

`default_nettype wire

// ===== sv/ocr_text_plausibility_checker.sv =====
// ocr_text_plausibility_checker: top level, byte stream in, one verdict word per line out
// depends on ocrpc_pkg, ocrpc_ram, ocrpc_verdict
// the verdict word is registered after the last byte passes the byte stage and snap_reg
// one byte per cycle with one histogram read-modify-write each, unless back-pressured
// reset: aresetn synchronous active low, clears line state, histogram valid bits,
//   pipeline valids and loads the register defaults; the histogram needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module ocr_text_plausibility_checker #(
    parameter int MAX_LINE_CHARS = 255
) (
    input  wire        aclk,
    input  wire        aresetn,

    // configuration write port
    input  wire        cfg_wr_en,
    input  wire [2:0]  cfg_addr,
    input  wire [7:0]  cfg_wr_data,

    // input stream
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [7:0]  s_tdata,     // [7:0] char_code
    input  wire        s_tlast,     // last_char

    // result stream
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [ocrpc_pkg::OUT_DATA_W-1:0] m_tdata
    // m_tdata from bit 0: line_plausible, small_plausible, numeric_geometry,
    // repetitive_geometry, punctuation_geometry, composition_score[11:0],
    // glyph_count[7:0], overflow, zero fill
);
    import ocrpc_pkg::*;

    localparam int LEN_W = $clog2(MAX_LINE_CHARS + 1);

    // configuration registers
    cfg_t cfg_reg;

    // byte stage: the accepted byte waits here while its histogram bin is read
    logic        st1_valid_reg;
    logic [7:0]  st1_char_reg;
    logic        st1_last_reg;

    // line state
    line_stats_t stats_reg, stats_next;
    logic [7:0]  pend_reg, pend_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [255:0] hist_vld_reg;

    // bypass for a bin written at the same edge that read it
    logic        fwd_hit_reg;
    logic [7:0]  fwd_val_reg;

    // finished line counts waiting for the verdict logic
    logic        snap_valid_reg;
    line_stats_t snap_reg;

    // result register
    logic        m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic        s_accept;
    logic        out_free, snap_free, st1_adv, snap_push, snap_pop;
    logic        in_range, glyph, pn;
    logic [7:0]  ram_q, bin_old, bin_new;
    logic [8:0]  space_sum;
    verdict_t    verdict;

    // handshake chain, output side backward to input side
    assign out_free  = !m_tvalid_reg || m_tready;
    assign snap_pop  = snap_valid_reg && out_free;
    assign snap_free = !snap_valid_reg || out_free;
    assign st1_adv   = st1_valid_reg && (!st1_last_reg || snap_free);
    assign snap_push = st1_adv && st1_last_reg;
    assign s_tready  = !st1_valid_reg || st1_adv;
    assign s_accept  = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // histogram store, read on accept, written when the byte stage retires a glyph
    ocrpc_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (st1_adv && glyph),
        .wr_addr (st1_char_reg),
        .wr_data (bin_new),
        .rd_en   (s_accept),
        .rd_addr (s_tdata),
        .rd_data (ram_q)
    );

    // bin value: bypass first, then stored bin if written this line, else zero
    always_comb begin
        if (fwd_hit_reg) begin
            bin_old = fwd_val_reg;
        end else if (hist_vld_reg[st1_char_reg]) begin
            bin_old = ram_q;
        end else begin
            bin_old = 8'd0;
        end
        bin_new = sat_inc(bin_old);
    end

    assign in_range = len_reg < LEN_W'(MAX_LINE_CHARS);
    assign glyph    = in_range && !is_space(st1_char_reg);
    assign pn       = is_punct(st1_char_reg);

    // line state update for the byte in the byte stage
    always_comb begin
        stats_next = stats_reg;
        pend_next  = pend_reg;
        len_next   = len_reg;
        space_sum  = 9'(stats_reg.spaces) + 9'(pend_reg);

        if (!in_range) begin
            // bytes past the length bound only flag overflow
            stats_next.ovf = 1'b1;
        end else begin
            len_next = len_reg + LEN_W'(1);
            if (is_space(st1_char_reg)) begin
                // whitespace only counts once a glyph has been seen
                if (stats_reg.edge_flags[2]) begin
                    pend_next = sat_inc(pend_reg);
                    if (pend_reg == 8'hFF) begin
                        stats_next.ovf = 1'b1;
                    end
                end
            end else begin
                // commit interior whitespace held since the previous glyph
                if (pend_reg == 8'hFF || space_sum > 9'd255) begin
                    stats_next.ovf = 1'b1;
                end
                stats_next.spaces = (space_sum > 9'd255) ? 8'hFF : space_sum[7:0];
                pend_next = 8'd0;

                stats_next.glyphs = sat_inc(stats_reg.glyphs);
                if (stats_reg.glyphs == 8'hFF) begin
                    stats_next.ovf = 1'b1;
                end
                if (is_letter(st1_char_reg)) begin
                    stats_next.letters = sat_inc(stats_reg.letters);
                    if (stats_reg.letters == 8'hFF) begin
                        stats_next.ovf = 1'b1;
                    end
                end else if (is_digit(st1_char_reg)) begin
                    stats_next.digits = sat_inc(stats_reg.digits);
                    if (stats_reg.digits == 8'hFF) begin
                        stats_next.ovf = 1'b1;
                    end
                end else if (pn) begin
                    stats_next.puncts = sat_inc(stats_reg.puncts);
                    if (stats_reg.puncts == 8'hFF) begin
                        stats_next.ovf = 1'b1;
                    end
                end else begin
                    stats_next.others = sat_inc(stats_reg.others);
                    if (stats_reg.others == 8'hFF) begin
                        stats_next.ovf = 1'b1;
                    end
                end

                // histogram bin saturation and running maximum
                if (bin_old == 8'hFF) begin
                    stats_next.ovf = 1'b1;
                end
                if (bin_new > stats_reg.top_freq) begin
                    stats_next.top_freq = bin_new;
                end

                // first glyph sets the seen bit and first-punct bit, every glyph the last-punct bit
                if (!stats_reg.edge_flags[2]) begin
                    stats_next.edge_flags = {1'b1, pn, pn};
                end else begin
                    stats_next.edge_flags = {1'b1, pn, stats_reg.edge_flags[0]};
                end
            end
        end
    end

    ocrpc_verdict u_verdict (
        .stats   (snap_reg),
        .cfg     (cfg_reg),
        .verdict (verdict)
    );

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_repeat_percent      <= RST_LINE_REPEAT;
            cfg_reg.geometry_repeat_percent  <= RST_GEO_REPEAT;
            cfg_reg.geometry_numeric_percent <= RST_GEO_NUMERIC;
            cfg_reg.geometry_pure_percent    <= RST_GEO_PURE;
            cfg_reg.small_max_glyphs         <= RST_SMALL_MAX;
            cfg_reg.small_numeric_percent    <= RST_SMALL_NUMBER;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_LINE_REPEAT:  cfg_reg.line_repeat_percent      <= cfg_wr_data[6:0];
                REG_GEO_REPEAT:   cfg_reg.geometry_repeat_percent  <= cfg_wr_data[6:0];
                REG_GEO_NUMERIC:  cfg_reg.geometry_numeric_percent <= cfg_wr_data[6:0];
                REG_GEO_PURE:     cfg_reg.geometry_pure_percent    <= cfg_wr_data[6:0];
                REG_SMALL_MAX:    cfg_reg.small_max_glyphs         <= cfg_wr_data;
                REG_SMALL_NUMBER: cfg_reg.small_numeric_percent    <= cfg_wr_data[6:0];
                default: ;
            endcase
        end
    end

    // byte stage and bypass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end else begin
            if (s_accept) begin
                st1_valid_reg <= 1'b1;
                // a bin written at this edge is not yet in the RAM read data
                fwd_hit_reg   <= st1_adv && glyph && !st1_last_reg &&
                                 (st1_char_reg == s_tdata);
            end else if (st1_adv) begin
                st1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_char_reg <= s_tdata;
            st1_last_reg <= s_tlast;
            fwd_val_reg  <= bin_new;
        end
    end

    // line state, cleared after the last byte of each line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stats_reg    <= '0;
            pend_reg     <= 8'd0;
            len_reg      <= '0;
            hist_vld_reg <= '0;
        end else if (st1_adv) begin
            if (st1_last_reg) begin
                stats_reg    <= '0;
                pend_reg     <= 8'd0;
                len_reg      <= '0;
                hist_vld_reg <= '0;
            end else begin
                stats_reg <= stats_next;
                pend_reg  <= pend_next;
                len_reg   <= len_next;
                if (glyph) begin
                    hist_vld_reg[st1_char_reg] <= 1'b1;
                end
            end
        end
    end

    // finished line counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (snap_push) begin
            snap_valid_reg <= 1'b1;
        end else if (snap_pop) begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_push) begin
            snap_reg <= stats_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (snap_pop) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_pop) begin
            m_tdata_reg <= OUT_DATA_W'({verdict.overflow,
                                        verdict.glyph_count,
                                        verdict.composition_score,
                                        verdict.punctuation_geometry,
                                        verdict.repetitive_geometry,
                                        verdict.numeric_geometry,
                                        verdict.small_plausible,
                                        verdict.line_plausible});
        end
    end

endmodule

`default_nettype wire
